/* rtl/core/ps2kbd_pkg.sv */
// shared types, constants and scan code table for the ps/2 keyboard queue
package ps2kbd_pkg;

    localparam logic [7:0] BYTE_BREAK = 8'hf0;
    localparam logic [7:0] BYTE_EXT   = 8'he0;
    localparam logic [7:0] BYTE_PAUSE = 8'he1;
    localparam int unsigned NUM_KEYS  = 101;

    typedef enum logic [1:0] {
        KIND_PLAIN = 2'd0,
        KIND_EXT   = 2'd1,
        KIND_PRTSC = 2'd2,
        KIND_PAUSE = 2'd3
    } key_kind_t;

    // classified request passed from front to back
    typedef struct packed {
        logic       is_status;
        logic       clear_bit;
        logic [3:0] len;
        logic [63:0] seq;      // byte 0 in bits 7:0
    } cmd_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_PUSH = 2'd1,
        ST_DONE = 2'd2
    } back_state_t;

    function automatic logic [9:0] key_entry(input logic [6:0] key);
        logic [9:0] e;
        e = {KIND_PLAIN, 8'h00};
        unique case (key)
            7'd0: e = {KIND_PLAIN, 8'h1c};   7'd1: e = {KIND_PLAIN, 8'h32};
            7'd2: e = {KIND_PLAIN, 8'h21};   7'd3: e = {KIND_PLAIN, 8'h23};
            7'd4: e = {KIND_PLAIN, 8'h24};   7'd5: e = {KIND_PLAIN, 8'h2b};
            7'd6: e = {KIND_PLAIN, 8'h34};   7'd7: e = {KIND_PLAIN, 8'h33};
            7'd8: e = {KIND_PLAIN, 8'h43};   7'd9: e = {KIND_PLAIN, 8'h3b};
            7'd10: e = {KIND_PLAIN, 8'h42};  7'd11: e = {KIND_PLAIN, 8'h4b};
            7'd12: e = {KIND_PLAIN, 8'h3a};  7'd13: e = {KIND_PLAIN, 8'h31};
            7'd14: e = {KIND_PLAIN, 8'h44};  7'd15: e = {KIND_PLAIN, 8'h4d};
            7'd16: e = {KIND_PLAIN, 8'h15};  7'd17: e = {KIND_PLAIN, 8'h2d};
            7'd18: e = {KIND_PLAIN, 8'h1b};  7'd19: e = {KIND_PLAIN, 8'h2c};
            7'd20: e = {KIND_PLAIN, 8'h3c};  7'd21: e = {KIND_PLAIN, 8'h2a};
            7'd22: e = {KIND_PLAIN, 8'h1d};  7'd23: e = {KIND_PLAIN, 8'h22};
            7'd24: e = {KIND_PLAIN, 8'h35};  7'd25: e = {KIND_PLAIN, 8'h1a};
            7'd26: e = {KIND_PLAIN, 8'h16};  7'd27: e = {KIND_PLAIN, 8'h1e};
            7'd28: e = {KIND_PLAIN, 8'h26};  7'd29: e = {KIND_PLAIN, 8'h25};
            7'd30: e = {KIND_PLAIN, 8'h2e};  7'd31: e = {KIND_PLAIN, 8'h36};
            7'd32: e = {KIND_PLAIN, 8'h3d};  7'd33: e = {KIND_PLAIN, 8'h3e};
            7'd34: e = {KIND_PLAIN, 8'h46};  7'd35: e = {KIND_PLAIN, 8'h45};
            7'd36: e = {KIND_PLAIN, 8'h5a};  7'd37: e = {KIND_PLAIN, 8'h76};
            7'd38: e = {KIND_PLAIN, 8'h66};  7'd39: e = {KIND_PLAIN, 8'h0d};
            7'd40: e = {KIND_PLAIN, 8'h29};  7'd41: e = {KIND_PLAIN, 8'h4e};
            7'd42: e = {KIND_PLAIN, 8'h55};  7'd43: e = {KIND_PLAIN, 8'h54};
            7'd44: e = {KIND_PLAIN, 8'h5b};  7'd45: e = {KIND_PLAIN, 8'h5d};
            7'd46: e = {KIND_PLAIN, 8'h4c};  7'd47: e = {KIND_PLAIN, 8'h52};
            7'd48: e = {KIND_PLAIN, 8'h0e};  7'd49: e = {KIND_PLAIN, 8'h41};
            7'd50: e = {KIND_PLAIN, 8'h49};  7'd51: e = {KIND_PLAIN, 8'h4a};
            7'd52: e = {KIND_PLAIN, 8'h58};  7'd53: e = {KIND_PLAIN, 8'h05};
            7'd54: e = {KIND_PLAIN, 8'h06};  7'd55: e = {KIND_PLAIN, 8'h04};
            7'd56: e = {KIND_PLAIN, 8'h0c};  7'd57: e = {KIND_PLAIN, 8'h03};
            7'd58: e = {KIND_PLAIN, 8'h0b};  7'd59: e = {KIND_PLAIN, 8'h83};
            7'd60: e = {KIND_PLAIN, 8'h0a};  7'd61: e = {KIND_PLAIN, 8'h01};
            7'd62: e = {KIND_PLAIN, 8'h09};  7'd63: e = {KIND_PLAIN, 8'h78};
            7'd64: e = {KIND_PLAIN, 8'h07};  7'd65: e = {KIND_PRTSC, 8'h00};
            7'd66: e = {KIND_PLAIN, 8'h7e};  7'd67: e = {KIND_PAUSE, 8'h00};
            7'd68: e = {KIND_EXT, 8'h70};    7'd69: e = {KIND_EXT, 8'h6c};
            7'd70: e = {KIND_EXT, 8'h7d};    7'd71: e = {KIND_EXT, 8'h71};
            7'd72: e = {KIND_EXT, 8'h69};    7'd73: e = {KIND_EXT, 8'h7a};
            7'd74: e = {KIND_EXT, 8'h74};    7'd75: e = {KIND_EXT, 8'h6b};
            7'd76: e = {KIND_EXT, 8'h72};    7'd77: e = {KIND_EXT, 8'h75};
            7'd78: e = {KIND_PLAIN, 8'h77};  7'd79: e = {KIND_EXT, 8'h4a};
            7'd80: e = {KIND_PLAIN, 8'h7c};  7'd81: e = {KIND_PLAIN, 8'h7b};
            7'd82: e = {KIND_PLAIN, 8'h79};  7'd83: e = {KIND_PLAIN, 8'h5a};
            7'd84: e = {KIND_PLAIN, 8'h69};  7'd85: e = {KIND_PLAIN, 8'h72};
            7'd86: e = {KIND_PLAIN, 8'h7a};  7'd87: e = {KIND_PLAIN, 8'h6b};
            7'd88: e = {KIND_PLAIN, 8'h73};  7'd89: e = {KIND_PLAIN, 8'h74};
            7'd90: e = {KIND_PLAIN, 8'h6c};  7'd91: e = {KIND_PLAIN, 8'h75};
            7'd92: e = {KIND_PLAIN, 8'h7d};  7'd93: e = {KIND_PLAIN, 8'h70};
            7'd94: e = {KIND_PLAIN, 8'h71};  7'd95: e = {KIND_PLAIN, 8'h14};
            7'd96: e = {KIND_PLAIN, 8'h12};  7'd97: e = {KIND_PLAIN, 8'h11};
            7'd98: e = {KIND_EXT, 8'h14};    7'd99: e = {KIND_PLAIN, 8'h59};
            7'd100: e = {KIND_EXT, 8'h11};
            default: e = {KIND_PLAIN, 8'h00};
        endcase
        return e;
    endfunction

endpackage

/* rtl/core/ps2kbd_front.sv */
// front end: accepts requests and builds the byte sequence of a key event
module ps2kbd_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              valid,
    output logic              ready,
    input  logic              mode,
    input  logic [6:0]        key_code,
    input  logic              key_released,
    input  logic              clear_bit,
    output logic              cmd_valid,
    input  logic              cmd_ready,
    output ps2kbd_pkg::cmd_t  cmd
);
    import ps2kbd_pkg::*;

    logic       q_valid_reg, q_valid_next;
    cmd_t       q_reg, q_next;
    cmd_t       built;
    logic [9:0] entry;
    key_kind_t  kind;
    logic [7:0] code;

    assign entry = key_entry(key_code);
    assign kind  = key_kind_t'(entry[9:8]);
    assign code  = entry[7:0];

    always_comb
    begin
        built           = '0;
        built.is_status = mode;
        built.clear_bit = clear_bit;
        if (!mode && ({25'd0, key_code} < NUM_KEYS))
        begin
            unique case (kind)
                KIND_PLAIN:
                begin
                    if (!key_released)
                    begin
                        built.len = 4'd1; built.seq[7:0] = code;
                    end
                    else
                    begin
                        built.len = 4'd2; built.seq[15:0] = {code, BYTE_BREAK};
                    end
                end
                KIND_EXT:
                begin
                    if (!key_released)
                    begin
                        built.len = 4'd2; built.seq[15:0] = {code, BYTE_EXT};
                    end
                    else
                    begin
                        built.len = 4'd3;
                        built.seq[23:0] = {code, BYTE_BREAK, BYTE_EXT};
                    end
                end
                KIND_PRTSC:
                begin
                    if (!key_released)
                    begin
                        built.len = 4'd4;
                        built.seq[31:0] = {8'h7c, BYTE_EXT, 8'h12, BYTE_EXT};
                    end
                    else
                    begin
                        built.len = 4'd6;
                        built.seq[47:0] = {8'h7c, BYTE_BREAK, BYTE_EXT,
                                           8'h12, BYTE_BREAK, BYTE_EXT};
                    end
                end
                KIND_PAUSE:
                begin
                    if (!key_released)
                    begin
                        built.len = 4'd8;
                        built.seq = {8'h77, BYTE_BREAK, 8'h14, BYTE_BREAK,
                                     BYTE_PAUSE, 8'h77, 8'h14, BYTE_PAUSE};
                    end
                end
            endcase
        end
    end

    // one-entry queue toward the back end
    assign ready     = !q_valid_reg || cmd_ready;
    assign cmd_valid = q_valid_reg;
    assign cmd       = q_reg;

    always_comb
    begin
        q_valid_next = q_valid_reg;
        q_next       = q_reg;
        if (cmd_ready)
            q_valid_next = 1'b0;
        if (valid && ready)
        begin
            q_valid_next = 1'b1;
            q_next       = built;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            q_valid_reg <= 1'b0;
        else
            q_valid_reg <= q_valid_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
    end
endmodule

/* rtl/core/ps2kbd_back.sv */
// back end: byte queue, interrupt logic and result register
module ps2kbd_back #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cmd_valid,
    output logic             cmd_ready,
    input  ps2kbd_pkg::cmd_t cmd,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [7:0]       data_byte,
    output logic             data_pending,
    output logic             irq_request,
    output logic             sequence_dropped
);
    import ps2kbd_pkg::*;

    localparam int unsigned AW = $clog2(QUEUE_DEPTH);
    localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);

    back_state_t state_reg, state_next;
    logic [7:0]    mem [QUEUE_DEPTH];
    logic [AW-1:0] rd_reg, rd_next, wr_reg, wr_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic          irq_reg, irq_next, last_clr_reg, last_clr_next;
    logic          pend_reg, pend_next, drop_reg, drop_next;
    logic [7:0]    pres_reg, pres_next;
    logic [7:0]    rd_data_reg;
    logic          present_reg, present_next;
    cmd_t          c_reg, c_next;
    logic [3:0]    idx_reg, idx_next;
    logic          ov_reg, ov_next;
    logic          we;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] rd_inc, wr_inc;
    logic          edge_clr;
    logic          done_go;
    logic          res_valid_reg, res_valid_next;
    logic [7:0]    out_byte_reg;
    logic          out_pend_reg, out_irq_reg, out_drop_reg;

    assign rd_inc = (rd_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
    assign wr_inc = (wr_reg == AW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
    assign edge_clr = c_reg.clear_bit && !last_clr_reg;

    // ST_DONE waits until the previous result has gone
    assign done_go = (state_reg == ST_DONE) && (!res_valid_reg || out_ready);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (cmd_valid) state_next = ST_PUSH;
            ST_PUSH:
                if (c_reg.is_status || ov_reg || idx_reg + 4'd1 >= c_reg.len)
                    state_next = ST_DONE;
            ST_DONE: if (done_go) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    always_comb
    begin
        cmd_ready     = (state_reg == ST_IDLE);
        c_next        = c_reg;
        idx_next      = idx_reg;
        ov_next       = ov_reg;
        rd_next       = rd_reg;
        wr_next       = wr_reg;
        cnt_next      = cnt_reg;
        irq_next      = irq_reg;
        last_clr_next = last_clr_reg;
        pend_next     = pend_reg;
        pres_next     = pres_reg;
        drop_next     = drop_reg;
        present_next  = 1'b0;
        we            = 1'b0;
        rd_addr       = rd_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    c_next   = cmd;
                    idx_next = '0;
                    ov_next  = !cmd.is_status &&
                        ({{(32-CW){1'b0}}, cnt_reg} + {28'd0, cmd.len} > QUEUE_DEPTH);
                end
            end
            ST_PUSH:
            begin
                if (c_reg.is_status)
                begin
                    if (edge_clr)
                    begin
                        irq_next  = 1'b0;
                        pend_next = 1'b0;
                        if (cnt_reg != '0)
                        begin
                            rd_next  = rd_inc;
                            rd_addr  = rd_inc;
                            cnt_next = cnt_reg - 1'b1;
                            present_next = (cnt_reg > CW'(1));
                        end
                    end
                    last_clr_next = c_reg.clear_bit;
                    drop_next     = 1'b0;
                end
                else if (ov_reg || c_reg.len == 4'd0)
                    drop_next = ov_reg;
                else
                begin
                    we       = 1'b1;
                    wr_next  = wr_inc;
                    idx_next = idx_reg + 4'd1;
                    c_next.seq = {8'h00, c_reg.seq[63:8]};
                    drop_next  = 1'b0;
                    if (idx_reg + 4'd1 >= c_reg.len)
                    begin
                        cnt_next = cnt_reg + CW'(c_reg.len);
                        present_next = !irq_reg;
                    end
                end
            end
            ST_DONE:
            begin
                if (present_reg && done_go)
                begin
                    pres_next = rd_data_reg;
                    pend_next = 1'b1;
                    irq_next  = 1'b1;
                end
            end
            default: ;
        endcase
    end

    assign out_valid        = res_valid_reg;
    assign data_byte        = out_byte_reg;
    assign data_pending     = out_pend_reg;
    assign irq_request      = out_irq_reg;
    assign sequence_dropped = out_drop_reg;

    always_comb
    begin
        res_valid_next = res_valid_reg;
        if (out_valid && out_ready)
            res_valid_next = 1'b0;
        if (done_go)
            res_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rd_reg        <= '0;
            wr_reg        <= '0;
            cnt_reg       <= '0;
            irq_reg       <= 1'b0;
            last_clr_reg  <= 1'b0;
            pend_reg      <= 1'b0;
            pres_reg      <= 8'h00;
            drop_reg      <= 1'b0;
            present_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
            out_byte_reg  <= 8'h00;
            out_pend_reg  <= 1'b0;
            out_irq_reg   <= 1'b0;
            out_drop_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rd_reg        <= rd_next;
            wr_reg        <= wr_next;
            cnt_reg       <= cnt_next;
            last_clr_reg  <= last_clr_next;
            drop_reg      <= drop_next;
            irq_reg       <= irq_next;
            pend_reg      <= pend_next;
            pres_reg      <= pres_next;
            res_valid_reg <= res_valid_next;
            if (state_reg == ST_PUSH)
                present_reg <= present_next;
            if (done_go)
            begin
                out_byte_reg <= pres_next;
                out_pend_reg <= pend_next;
                out_irq_reg  <= irq_next;
                out_drop_reg <= drop_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        c_reg   <= c_next;
        idx_reg <= idx_next;
        ov_reg  <= ov_next;
        if (we)
            mem[wr_reg] <= c_reg.seq[7:0];
        // a byte pushed into an empty queue is forwarded to the head read
        if (we && wr_reg == rd_addr)
            rd_data_reg <= c_reg.seq[7:0];
        else
            rd_data_reg <= mem[(state_reg == ST_PUSH) ? rd_addr : rd_reg];
    end
endmodule

/* rtl/core/ps2_keyboard_scancode_fifo.sv */
// ps/2 set 2 keyboard front end with a scan code byte queue
// requests come in on valid/ready: mode 0 is a key event (key_code,
// key_released), mode 1 is a status port write (clear_bit).
// every request gives one result on valid/ready: data_byte, data_pending,
// irq_request and sequence_dropped as they stand after the request.
// a key event pushes its 1 to 8 bytes into the queue one per cycle; its
// result is valid once its last byte is in the queue and the result presented.
// a status write, a dropped sequence or an empty one pushes no byte.
// the back end picks up a request in ST_IDLE, pushes its bytes in ST_PUSH
// and presents the result in ST_DONE, so it takes no new request before
// it is through with the last one.
// a one-entry queue sits between the front and the back end, so the next
// request is taken while the current one is still pushing.
// a sequence that does not fit in the queue is dropped and flagged.
// reset clears the pointers, the interrupt and the presented byte; queue
// contents are not cleared. a stalled receiver holds the result in the
// output register, the back end then waits with the next result and, once
// the inner queue fills, new requests are held off.
module ps2_keyboard_scancode_fifo #(
    parameter int unsigned QUEUE_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       mode,
    input  logic [6:0] key_code,
    input  logic       key_released,
    input  logic       clear_bit,
    output logic       out_valid,
    input  logic       out_ready,
    output logic [7:0] data_byte,
    output logic       data_pending,
    output logic       irq_request,
    output logic       sequence_dropped
);
    import ps2kbd_pkg::*;

    logic cmd_valid, cmd_ready;
    cmd_t cmd;

    ps2kbd_front u_front (
        .clk, .rst_n, .valid(in_valid), .ready(in_ready), .mode, .key_code,
        .key_released, .clear_bit, .cmd_valid, .cmd_ready, .cmd
    );

    ps2kbd_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
        .clk, .rst_n, .cmd_valid, .cmd_ready, .cmd, .out_valid, .out_ready,
        .data_byte, .data_pending, .irq_request, .sequence_dropped
    );
endmodule

/* rtl/core/ps2kbd_checker.sv */
// port-level checks for the keyboard queue
module ps2kbd_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [7:0] data_byte,
    input logic       data_pending,
    input logic       irq_request
);
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(data_byte))
        else $error("result dropped while stalled");
    a_irq_pend: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> irq_request == data_pending)
        else $error("interrupt and pending disagree");
    a_reset_out: assert property (@(posedge clk)
        !rst_n |=> !out_valid || $past(rst_n))
        else $error("result after reset");
    a_out_known: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !$isunknown({data_byte, data_pending, irq_request}))
        else $error("unknown result");
endmodule

bind ps2_keyboard_scancode_fifo ps2kbd_checker u_checker (
    .clk, .rst_n, .out_valid, .out_ready,
    .data_byte, .data_pending, .irq_request
);
